// ===== hdl/egcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared state type and sequencer codes for the extended gcd / modular inverse block.
// ----------------------------------------------------------------------------
package egcd_pkg;

  typedef logic [1:0] state_t;

  localparam state_t ST_IDLE  = 2'd0;
  localparam state_t ST_CHECK = 2'd1;
  localparam state_t ST_DIV   = 2'd2;
  localparam state_t ST_UPD   = 2'd3;

endpackage

// ===== hdl/extended_gcd_mod_inverse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extended_gcd_mod_inverse
// Extended Euclidean algorithm: gcd, Bezout coefficients and modular inverse.
// ----------------------------------------------------------------------------
// One operand pair is taken at a time; in_stall stays high from the input
// transfer until the sequencer is idle again. Each quotient step uses a
// restoring shift-subtract divider, one quotient bit per cycle, that also
// builds q*x and q*y by shift-add; a step is a test, the divide, then the
// coefficient update. With 32-bit operands an item needs up to about 47
// quotient steps. A finished result waits in the output register while the
// next pair may already be taken.
// inverse_value is coeff_x unreduced (may be negative) when the gcd is one.
// ----------------------------------------------------------------------------
module extended_gcd_mod_inverse #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [OPERAND_WIDTH-1:0]        in_operand_a,
  input  logic [OPERAND_WIDTH-1:0]        in_operand_b,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [OPERAND_WIDTH-1:0]        out_gcd_value,
  output logic signed [OPERAND_WIDTH:0]   out_coeff_x,
  output logic signed [OPERAND_WIDTH:0]   out_coeff_y,
  output logic signed [OPERAND_WIDTH:0]   out_inverse_value,
  output logic                            out_invertible
);

  localparam int W     = OPERAND_WIDTH;
  localparam int CW    = OPERAND_WIDTH + 1;
  localparam int CNT_W = $clog2(OPERAND_WIDTH);

  egcd_pkg::state_t state_r, state_nxt;

  logic [W-1:0]          u_r, u_nxt, v_r, v_nxt;
  logic [W-1:0]          rem_r, rem_nxt, dvd_r, dvd_nxt;
  logic signed [CW-1:0]  xp_r, xp_nxt, xc_r, xc_nxt;
  logic signed [CW-1:0]  yp_r, yp_nxt, yc_r, yc_nxt;
  logic signed [CW-1:0]  qx_r, qx_nxt, qy_r, qy_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [W-1:0]          gcd_r, gcd_nxt;
  logic signed [CW-1:0]  cx_r, cx_nxt, cy_r, cy_nxt, inv_r, inv_nxt;
  logic                  invb_r, invb_nxt;

  logic [W:0]            trial;
  logic [W:0]            trial_diff;
  logic                  ge;
  logic                  in_xfer, out_xfer;

  assign in_stall = (state_r != egcd_pkg::ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;

  // shared divide step
  assign trial      = {rem_r, dvd_r[W-1]};
  assign ge         = (trial >= {1'b0, v_r});
  assign trial_diff = trial - {1'b0, v_r};

  always_comb begin
    state_nxt     = state_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    xp_nxt        = xp_r;
    xc_nxt        = xc_r;
    yp_nxt        = yp_r;
    yc_nxt        = yc_r;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    cnt_nxt       = cnt_r;
    gcd_nxt       = gcd_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    inv_nxt       = inv_r;
    invb_nxt      = invb_r;
    out_valid_nxt = out_valid_r && !out_xfer;

    unique case (state_r)
      egcd_pkg::ST_IDLE: begin
        if (in_xfer) begin
          u_nxt     = in_operand_a;
          v_nxt     = in_operand_b;
          xp_nxt    = CW'(1);
          xc_nxt    = '0;
          yp_nxt    = '0;
          yc_nxt    = CW'(1);
          state_nxt = egcd_pkg::ST_CHECK;
        end
      end
      egcd_pkg::ST_CHECK: begin
        if (v_r != '0) begin
          rem_nxt   = '0;
          dvd_nxt   = u_r;
          qx_nxt    = '0;
          qy_nxt    = '0;
          cnt_nxt   = CNT_W'(W - 1);
          state_nxt = egcd_pkg::ST_DIV;
        end else if (!out_valid_r || !out_stall) begin
          gcd_nxt       = u_r;
          cx_nxt        = xp_r;
          cy_nxt        = yp_r;
          invb_nxt      = (u_r == W'(1));
          inv_nxt       = (u_r == W'(1)) ? xp_r : '0;
          out_valid_nxt = 1'b1;
          state_nxt     = egcd_pkg::ST_IDLE;
        end
      end
      egcd_pkg::ST_DIV: begin
        rem_nxt = ge ? trial_diff[W-1:0] : trial[W-1:0];
        dvd_nxt = {dvd_r[W-2:0], 1'b0};
        qx_nxt  = {qx_r[CW-2:0], 1'b0} + (ge ? xc_r : '0);
        qy_nxt  = {qy_r[CW-2:0], 1'b0} + (ge ? yc_r : '0);
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = egcd_pkg::ST_UPD;
        end
      end
      egcd_pkg::ST_UPD: begin
        u_nxt     = v_r;
        v_nxt     = rem_r;
        xp_nxt    = xc_r;
        xc_nxt    = xp_r - qx_r;
        yp_nxt    = yc_r;
        yc_nxt    = yp_r - qy_r;
        state_nxt = egcd_pkg::ST_CHECK;
      end
      default: begin
        state_nxt = egcd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= egcd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_r    <= u_nxt;
    v_r    <= v_nxt;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    xp_r   <= xp_nxt;
    xc_r   <= xc_nxt;
    yp_r   <= yp_nxt;
    yc_r   <= yc_nxt;
    qx_r   <= qx_nxt;
    qy_r   <= qy_nxt;
    cnt_r  <= cnt_nxt;
    gcd_r  <= gcd_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    inv_r  <= inv_nxt;
    invb_r <= invb_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_gcd_value     = gcd_r;
  assign out_coeff_x       = cx_r;
  assign out_coeff_y       = cy_r;
  assign out_inverse_value = inv_r;
  assign out_invertible    = invb_r;

  // divisor never zero and remainder below it while dividing
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == egcd_pkg::ST_DIV) |-> (v_r != '0 && rem_r < v_r))
    else $error("divide step with bad divisor or remainder");

  a_in_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == egcd_pkg::ST_CHECK))
    else $error("input transfer did not start the sequencer");

  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == egcd_pkg::ST_DIV && cnt_r == '0) |=> (state_r == egcd_pkg::ST_UPD))
    else $error("divide did not end in update");

  a_flag_match: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (out_invertible == (out_gcd_value == W'(1))))
    else $error("invertible flag disagrees with gcd");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(gcd_r) && $stable(cx_r)))
    else $error("pending result overwritten");

endmodule
